[design/mlpbp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlpbp_pkg
// Types, constants and fixed-point helpers shared by the MLP training core.
// ----------------------------------------------------------------------------
package mlpbp_pkg;

	localparam int unsigned WordW = 16;
	localparam int unsigned OutW  = 13;
	localparam int unsigned IdxW  = 7;
	localparam logic [OutW-1:0] LrReset = OutW'(614);
	localparam logic signed [16:0] QOne = 17'sd4096;

	typedef logic signed [WordW-1:0] word_t;

	typedef enum logic [1:0] {
		MODE_LOAD  = 2'd0,
		MODE_INFER = 2'd1,
		MODE_TRAIN = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		L_IDLE,
		L_MUL_X0,
		L_ACC_B,
		L_ACC_H,
		L_MUL_OUT,
		L_DH_MUL,
		L_DH_SET,
		L_G0,
		L_LR,
		L_W0_G1,
		L_W1_GB,
		L_B_GO,
		L_WO
	} lane_op_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOAD,
		S_FWD,
		S_MERGE,
		S_DOUT,
		S_BWD,
		S_DONE
	} top_state_t;

	typedef struct packed {
		lane_op_t        op;
		word_t           x0;
		word_t           x1;
		word_t           dout;
		logic [OutW-1:0] lr;
		logic            ld_en;
		logic [IdxW-1:0] widx;
		word_t           wval;
	} lane_ctl_t;

	function automatic word_t sat17(input logic signed [16:0] v);
		if (v > 17'sd32767) return 16'sh7fff;
		if (v < -17'sd32768) return 16'sh8000;
		return v[15:0];
	endfunction

	function automatic word_t sat_add(input word_t a, input word_t b);
		logic signed [16:0] s;
		s = 17'(a) + 17'(b);
		return sat17(s);
	endfunction

	function automatic word_t sat_sub(input word_t a, input word_t b);
		logic signed [16:0] s;
		s = 17'(a) - 17'(b);
		return sat17(s);
	endfunction

	// product rounded half up, floor shift by 12, saturated to 16 bits
	function automatic word_t qmul(input logic signed [16:0] a, input word_t b);
		logic signed [33:0] p;
		logic signed [21:0] q;
		p = 34'(a) * 34'(b) + 34'sd2048;
		q = p[33:12];
		if (q > 22'sd32767) return 16'sh7fff;
		if (q < -22'sd32768) return 16'sh8000;
		return q[15:0];
	endfunction

	// one table entry at point xq (Q4.12), the sigmoid of -xq, evaluated at elaboration
	function automatic logic [OutW-1:0] sig_entry(input int xq);
		logic [63:0] one, t, u, u2, u3, u4, r, den, num, rem, quo;
		one = 64'd1 << 31;
		t   = (xq < 0) ? 64'(-xq) : 64'(xq);
		u   = t << 11;
		u2  = (u * u) >> 31;
		u3  = (u2 * u) >> 31;
		u4  = (u3 * u) >> 31;
		r   = (one + (u2 >> 1) + u4 / 24) - (u + u3 / 6);
		for (int s = 0; s < 8; s++) r = (r * r) >> 31;
		den = one + r;
		num = (64'd1 << 43) + (den >> 1);
		rem = '0;
		quo = '0;
		for (int b = 45; b >= 0; b--) begin
			rem = (rem << 1) | ((num >> b) & 64'd1);
			quo = quo << 1;
			if (rem >= den) begin
				rem = rem - den;
				quo = quo | 64'd1;
			end
		end
		return (xq < 0) ? quo[OutW-1:0] : OutW'(13'd4096 - quo[OutW-1:0]);
	endfunction

endpackage
`default_nettype wire

[design/mlpbp_lane.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlpbp_lane
// One hidden unit: holds its weights, runs its share of forward, backward
// and update steps on a private multiplier, one operation a cycle.
// ----------------------------------------------------------------------------
module mlpbp_lane #(
	parameter int LANE   = 0,
	parameter int HCOUNT = 2
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  mlpbp_pkg::lane_ctl_t   ctl,
	output mlpbp_pkg::word_t       prod,
	output logic                   chg,
	output logic                   ld_chg
);
	import mlpbp_pkg::*;

	localparam logic [IdxW-1:0] AddrW0 = IdxW'(LANE);
	localparam logic [IdxW-1:0] AddrW1 = IdxW'(HCOUNT + LANE);
	localparam logic [IdxW-1:0] AddrB  = IdxW'(2 * HCOUNT + LANE);
	localparam logic [IdxW-1:0] AddrWo = IdxW'(3 * HCOUNT + LANE);

	word_t w0_q, w1_q, b_q, wo_q;
	word_t prod_q, acc_q, hv_q, dh_q;
	logic  chg_q;
	word_t ha, nv;
	logic signed [16:0] ma;
	word_t mb;
	logic  hit0, hit1, hitb, hito;

	assign ha = hv_q[WordW-1] ? '0 : hv_q;
	assign nv = sat_sub(
		(ctl.op == L_W0_G1) ? w0_q :
		(ctl.op == L_W1_GB) ? w1_q :
		(ctl.op == L_B_GO)  ? b_q  : wo_q, prod_q);

	assign hit0 = ctl.widx == AddrW0;
	assign hit1 = ctl.widx == AddrW1;
	assign hitb = ctl.widx == AddrB;
	assign hito = ctl.widx == AddrWo;
	assign ld_chg = (hit0 && w0_q != ctl.wval) || (hit1 && w1_q != ctl.wval)
		|| (hitb && b_q != ctl.wval) || (hito && wo_q != ctl.wval);

	// operand select for the lane multiplier
	always_comb begin
		ma = 17'(w0_q);
		mb = ctl.x0;
		case (ctl.op)
			L_ACC_B:   begin ma = 17'(w1_q);  mb = ctl.x1;   end
			L_MUL_OUT: begin ma = 17'(wo_q);  mb = ha;       end
			L_DH_MUL:  begin ma = 17'(wo_q);  mb = ctl.dout; end
			L_G0:      begin ma = 17'(dh_q);  mb = ctl.x0;   end
			L_LR:      begin ma = 17'(ctl.lr); mb = prod_q;  end
			L_W0_G1:   begin ma = 17'(dh_q);  mb = ctl.x1;   end
			L_W1_GB:   begin ma = 17'(ctl.lr); mb = dh_q;    end
			L_B_GO:    begin ma = 17'(ctl.dout); mb = ha;    end
			default:   begin ma = 17'(w0_q);  mb = ctl.x0;   end
		endcase
	end

	always_ff @(posedge clk) begin
		case (ctl.op)
			L_MUL_X0, L_ACC_B, L_MUL_OUT, L_DH_MUL, L_G0, L_LR,
			L_W0_G1, L_W1_GB, L_B_GO: prod_q <= qmul(ma, mb);
			default: prod_q <= prod_q;
		endcase
		if (ctl.op == L_ACC_B) acc_q <= sat_add(b_q, prod_q);
		if (ctl.op == L_ACC_H) hv_q <= sat_add(acc_q, prod_q);
		if (ctl.op == L_DH_SET) dh_q <= hv_q[WordW-1] ? '0 : prod_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w0_q  <= '0;
			w1_q  <= '0;
			b_q   <= '0;
			wo_q  <= '0;
			chg_q <= 1'b0;
		end else if (ctl.ld_en) begin
			if (hit0) w0_q <= ctl.wval;
			if (hit1) w1_q <= ctl.wval;
			if (hitb) b_q  <= ctl.wval;
			if (hito) wo_q <= ctl.wval;
		end else begin
			case (ctl.op)
				L_MUL_X0: chg_q <= 1'b0;
				L_W0_G1:  begin w0_q <= nv; chg_q <= chg_q | (nv != w0_q); end
				L_W1_GB:  begin w1_q <= nv; chg_q <= chg_q | (nv != w1_q); end
				L_B_GO:   begin b_q  <= nv; chg_q <= chg_q | (nv != b_q);  end
				L_WO:     begin wo_q <= nv; chg_q <= chg_q | (nv != wo_q); end
				default:  chg_q <= chg_q;
			endcase
		end
	end

	assign prod = prod_q;
	assign chg  = chg_q;

endmodule
`default_nettype wire

[design/mlpbp_merge.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlpbp_merge
// Folds the lane contributions into the output sum one lane a cycle with
// saturation, then looks the sum up in the sigmoid table.
// ----------------------------------------------------------------------------
module mlpbp_merge #(
	parameter int HCOUNT = 2,
	parameter int DEPTH  = 256
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    start,
	input  mlpbp_pkg::word_t       bias,
	input  mlpbp_pkg::word_t       contrib [HCOUNT],
	output logic [12:0]            sig,
	output logic                   done
);
	import mlpbp_pkg::*;

	localparam int CW = $clog2(HCOUNT + 2);
	localparam int LW = (HCOUNT > 1) ? $clog2(HCOUNT) : 1;
	localparam int IW = $clog2(DEPTH);
	localparam int PW = WordW + IW + 1;

	logic [OutW-1:0] tab [DEPTH];

	for (genvar k = 0; k < DEPTH; k++) begin : g_tab
		localparam int XQ = -32768 + ((2 * k + 1) * 32768) / DEPTH;
		localparam logic [OutW-1:0] V = sig_entry(XQ);
		assign tab[k] = V;
	end

	word_t           ov_q;
	logic [CW-1:0]   cnt_q;
	logic [IW-1:0]   idx_q;
	logic [OutW-1:0] sig_q;
	logic            busy_q, done_q;
	logic [PW-1:0]   scaled;

	// offset binary of the sum, scaled to the table depth
	assign scaled = PW'({~ov_q[WordW-1], ov_q[WordW-2:0]}) * PW'(DEPTH);

	always_ff @(posedge clk) begin
		if (start) ov_q <= bias;
		else if (busy_q && cnt_q < CW'(HCOUNT)) ov_q <= sat_add(ov_q, contrib[cnt_q[LW-1:0]]);
		if (busy_q && cnt_q == CW'(HCOUNT)) idx_q <= scaled[WordW +: IW];
		if (busy_q && cnt_q == CW'(HCOUNT + 1)) sig_q <= tab[idx_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				if (cnt_q == CW'(HCOUNT + 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign sig  = sig_q;
	assign done = done_q;

endmodule
`default_nettype wire

[design/mlp_backprop_train_step_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlp_backprop_train_step_core
// Two-input perceptron with ReLU hidden lanes and a sigmoid output; loads
// weights, infers, or trains one sample by backpropagation and SGD.
// ----------------------------------------------------------------------------
//  channel   handshake               payload
//  in        in_valid / in_stall     mode, feature_0, feature_1, target,
//                                    weight_index, weight_value
//  out       out_valid / out_stall   output_value, output_bit, updated
//  config    learning_rate_we        learning_rate_wdata
//
//  transfer to result: load runs S_LOAD then S_DONE, an unused mode goes
//  straight to S_DONE; infer runs the forward steps and the one-lane-a-cycle
//  output merge, and train adds the output delta and the ten-step lane update
//  sequence on each lane's single multiplier; then the core returns to S_IDLE.
//  in_stall is high from a transfer until its result sits in the output
//  register; a result waits there under out_stall while the next item runs.
//  reset clears all weights and biases and sets the learning rate to 614.
// ----------------------------------------------------------------------------
module mlp_backprop_train_step_core #(
	parameter int HIDDEN_COUNT        = 2,
	parameter int SIGMOID_TABLE_DEPTH = 256
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                learning_rate_we,
	input  wire  [12:0]        learning_rate_wdata,
	input  wire                in_valid,
	output logic               in_stall,
	input  wire  [1:0]         mode,
	input  wire  signed [15:0] feature_0,
	input  wire  signed [15:0] feature_1,
	input  wire  [12:0]        target,
	input  wire  [6:0]         weight_index,
	input  wire  signed [15:0] weight_value,
	output logic               out_valid,
	input  wire                out_stall,
	output logic [12:0]        output_value,
	output logic               output_bit,
	output logic               updated
);
	import mlpbp_pkg::*;

	localparam logic [IdxW-1:0] AddrOb = IdxW'(4 * HIDDEN_COUNT);

	top_state_t      state_q, state_d;
	logic [3:0]      step_q;
	mode_t           mode_q;
	word_t           x0_q, x1_q, wval_q, ob_q, tprod_q, dout_q;
	logic [OutW-1:0] tgt_q, lr_q;
	logic [IdxW-1:0] widx_q;
	logic            chg_q, mstart_q, mdone;
	logic [OutW-1:0] sig;
	logic            out_valid_q, out_bit_q, upd_q;
	logic [OutW-1:0] out_val_q;
	lane_ctl_t       ctl;
	lane_op_t        op;
	word_t           contrib [HIDDEN_COUNT];
	logic [HIDDEN_COUNT-1:0] lane_chg, lane_ld;
	logic            accept, out_free, ld_hit;
	logic signed [16:0] err, comp, ma;
	word_t           mb, ob_new;

	assign accept   = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_free = !out_valid_q || !out_stall;
	assign ld_hit   = (|lane_ld) || (widx_q == AddrOb && ob_q != wval_q);

	// lane operation for the current step
	always_comb begin
		op = L_IDLE;
		if (state_q == S_FWD) begin
			case (step_q)
				4'd0:    op = L_MUL_X0;
				4'd1:    op = L_ACC_B;
				4'd2:    op = L_ACC_H;
				default: op = L_MUL_OUT;
			endcase
		end else if (state_q == S_BWD) begin
			case (step_q)
				4'd0:    op = L_DH_MUL;
				4'd1:    op = L_DH_SET;
				4'd2:    op = L_G0;
				4'd3:    op = L_LR;
				4'd4:    op = L_W0_G1;
				4'd5:    op = L_LR;
				4'd6:    op = L_W1_GB;
				4'd7:    op = L_B_GO;
				4'd8:    op = L_LR;
				default: op = L_WO;
			endcase
		end
	end

	always_comb begin
		ctl.op    = op;
		ctl.x0    = x0_q;
		ctl.x1    = x1_q;
		ctl.dout  = dout_q;
		ctl.lr    = lr_q;
		ctl.ld_en = state_q == S_LOAD;
		ctl.widx  = widx_q;
		ctl.wval  = wval_q;
	end

	for (genvar j = 0; j < HIDDEN_COUNT; j++) begin : g_lane
		mlpbp_lane #(
			.LANE   (j),
			.HCOUNT (HIDDEN_COUNT)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.ctl    (ctl),
			.prod   (contrib[j]),
			.chg    (lane_chg[j]),
			.ld_chg (lane_ld[j])
		);
	end

	mlpbp_merge #(
		.HCOUNT (HIDDEN_COUNT),
		.DEPTH  (SIGMOID_TABLE_DEPTH)
	) u_merge (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (mstart_q),
		.bias    (ob_q),
		.contrib (contrib),
		.sig     (sig),
		.done    (mdone)
	);

	// output delta and output bias update share one multiplier
	assign err  = 17'($signed({1'b0, sig})) - 17'($signed({1'b0, tgt_q}));
	assign comp = QOne - 17'($signed({1'b0, sig}));
	always_comb begin
		ma = err;
		mb = WordW'(sig);
		if (state_q == S_DOUT && step_q != 4'd0) begin
			ma = comp;
			mb = tprod_q;
		end else if (state_q == S_BWD) begin
			ma = 17'(lr_q);
			mb = dout_q;
		end
	end
	assign ob_new = sat_sub(ob_q, tprod_q);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (mode_t'(mode))
						MODE_LOAD:              state_d = S_LOAD;
						MODE_INFER, MODE_TRAIN: state_d = S_FWD;
						default:                state_d = S_DONE;
					endcase
				end
			end
			S_LOAD:  state_d = S_DONE;
			S_FWD:   if (step_q == 4'd3) state_d = S_MERGE;
			S_MERGE: if (mdone) state_d = (mode_q == MODE_TRAIN) ? S_DOUT : S_DONE;
			S_DOUT:  if (step_q == 4'd1) state_d = S_BWD;
			S_BWD:   if (step_q == 4'd9) state_d = S_DONE;
			S_DONE:  if (out_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			x0_q   <= feature_0;
			x1_q   <= feature_1;
			tgt_q  <= target;
			widx_q <= weight_index;
			wval_q <= weight_value;
		end
		if (state_q == S_DOUT || (state_q == S_BWD && step_q == 4'd0)) tprod_q <= qmul(ma, mb);
		if (state_q == S_DOUT && step_q == 4'd1) dout_q <= qmul(ma, mb);
		if (state_q == S_DONE && out_free) begin
			out_val_q <= '0;
			out_bit_q <= 1'b0;
			upd_q     <= 1'b0;
			case (mode_q)
				MODE_LOAD: upd_q <= chg_q;
				MODE_INFER: begin
					out_val_q <= sig;
					out_bit_q <= sig[12] | sig[11];
				end
				MODE_TRAIN: begin
					out_val_q <= sig;
					out_bit_q <= sig[12] | sig[11];
					upd_q     <= chg_q | (|lane_chg);
				end
				default: upd_q <= 1'b0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			lr_q        <= LrReset;
			ob_q        <= '0;
			chg_q       <= 1'b0;
			mstart_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			mstart_q <= state_q == S_FWD && step_q == 4'd3;
			if (learning_rate_we) lr_q <= learning_rate_wdata;
			step_q <= (state_d != state_q) ? '0 : step_q + 1'b1;
			if (accept) chg_q <= 1'b0;
			if (state_q == S_LOAD) begin
				chg_q <= ld_hit;
				if (widx_q == AddrOb) ob_q <= wval_q;
			end
			if (state_q == S_BWD && step_q == 4'd1) begin
				ob_q  <= ob_new;
				chg_q <= chg_q | (ob_new != ob_q);
			end
			if (state_q == S_DONE && out_free) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	assign out_valid    = out_valid_q;
	assign output_value = out_val_q;
	assign output_bit   = out_bit_q;
	assign updated      = upd_q;

endmodule
`default_nettype wire

[design/mlpbp_chk.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mlpbp_chk
// Port-level checks for the MLP training core, bound to the top level.
// ----------------------------------------------------------------------------
module mlpbp_chk (
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_stall,
	input wire        out_valid,
	input wire        out_stall,
	input wire [12:0] output_value,
	input wire        output_bit,
	input wire        updated
);

	// a waiting result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(output_value)
			&& $stable(output_bit) && $stable(updated))
		else $error("result changed while stalled");

	// one item at a time: busy right after a transfer
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

	// class decision agrees with the value
	a_bit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> output_bit == (output_value[12] | output_value[11]))
		else $error("output_bit disagrees with output_value");

	// the output value never exceeds one
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && output_value[12] |-> output_value[11:0] == 12'd0)
		else $error("output_value above one");

endmodule

bind mlp_backprop_train_step_core mlpbp_chk u_mlpbp_chk (.*);
`default_nettype wire
